// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic property check.
`define LZWC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same-cycle implication.
`define LZWC_IMPLY(name, ante, cons, msg) \
   `LZWC_ASSERT(name, (ante) |-> (cons), msg)

// Next-cycle implication.
`define LZWC_NEXT(name, ante, cons, msg) \
   `LZWC_ASSERT(name, (ante) |=> (cons), msg)

`endif

// ===== design/lzwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor package
// Constants and types shared by the compressor's sequencer, dictionary and
// output queue.
// ----------------------------------------------------------------------------
package lzwc_pkg;

   // Default code width.
   localparam int CODE_BITS_DEFAULT = 16;

   // First dictionary code; codes below it stand for single bytes.
   localparam int FIRST_CODE = 256;

   // Width of the emitted code field and of the input byte.
   localparam int OUT_CODE_W = 16;
   localparam int BYTE_W     = 8;

   // Multiplicative hash constant for the slot index.
   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   // One result item on its way to the output queue.
   typedef struct packed {
      logic [OUT_CODE_W-1:0] code;
      logic                  last;
   } out_item_type;

   // Memory commands from the sequencer to the dictionary.
   typedef struct packed {
      logic slot_rd;
      logic entry_rd;
      logic wr;
   } dict_cmd_type;

endpackage

// ===== design/lzw_compressor_16bit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor, fixed 16-bit codes
// Byte stream in, LZW codes out, with a hashed dictionary in block memory.
// ----------------------------------------------------------------------------
// Each byte is one item on req_; the byte flagged with req_tlast ends the
// stream and also flushes the final prefix code with rsp_tlast set, after
// which the next byte starts a fresh dictionary. The first byte of a stream
// sets the prefix without a dictionary access. Every later byte passes
// through hash and accept, slot read, slot check, then an entry compare or
// the code emit; a slot holding a code left over from an earlier stream
// takes both the entry compare and the emit, each extra hash collision walked
// adds another slot check and entry compare, and a byte that ends the stream
// adds the flush, along the serial read and compare chain through the two
// registered dictionary memories. Results wait in a two-entry output queue,
// so a stalled result channel holds the block only when a code must be emitted
// into a full queue. Hash slots are validated by a back-pointer stored with
// each entry, so no clearing pass is needed after reset or between streams.
module lzw_compressor_16bit #(
   parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte[7:0]
   input  logic        req_tlast,    // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // code[15:0]
   output logic        rsp_tlast     // last
);

   lzwc_pkg::dict_cmd_type      cmd;
   lzwc_pkg::out_item_type      emit_item;
   logic                        emit_valid;
   logic                        emit_space;
   logic [CODE_BITS:0]          rd_slot;
   logic [CODE_BITS-1:0]        rd_code;
   logic [CODE_BITS:0]          wr_slot;
   logic [CODE_BITS-1:0]        wr_code;
   logic [CODE_BITS-1:0]        wr_prefix;
   logic [lzwc_pkg::BYTE_W-1:0] wr_byte;
   logic [CODE_BITS-1:0]        slot_code;
   logic [CODE_BITS-1:0]        entry_prefix;
   logic [lzwc_pkg::BYTE_W-1:0] entry_byte;
   logic [CODE_BITS:0]          entry_slot;

   lzwc_ctrl #(
      .CODE_BITS (CODE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_byte      (req_tdata),
      .in_eod       (req_tlast),
      .emit_valid   (emit_valid),
      .emit_item    (emit_item),
      .emit_space   (emit_space),
      .cmd          (cmd),
      .rd_slot      (rd_slot),
      .rd_code      (rd_code),
      .wr_slot      (wr_slot),
      .wr_code      (wr_code),
      .wr_prefix    (wr_prefix),
      .wr_byte      (wr_byte),
      .slot_code    (slot_code),
      .entry_prefix (entry_prefix),
      .entry_byte   (entry_byte),
      .entry_slot   (entry_slot)
   );

   lzwc_dict #(
      .CODE_BITS (CODE_BITS)
   ) u_dict (
      .clock        (clock),
      .cmd          (cmd),
      .rd_slot      (rd_slot),
      .rd_code      (rd_code),
      .wr_slot      (wr_slot),
      .wr_code      (wr_code),
      .wr_prefix    (wr_prefix),
      .wr_byte      (wr_byte),
      .slot_code    (slot_code),
      .entry_prefix (entry_prefix),
      .entry_byte   (entry_byte),
      .entry_slot   (entry_slot)
   );

   lzwc_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (emit_valid),
      .push_item  (emit_item),
      .push_space (emit_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/lzwc_dict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW dictionary memories
// A hash slot table that maps slots to codes, and an entry table that holds
// each code's (prefix, byte) pair together with the slot that claims it.
// ----------------------------------------------------------------------------
module lzwc_dict #(
   parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  lzwc_pkg::dict_cmd_type    cmd,
   input  logic [CODE_BITS:0]        rd_slot,
   input  logic [CODE_BITS-1:0]      rd_code,
   input  logic [CODE_BITS:0]        wr_slot,
   input  logic [CODE_BITS-1:0]      wr_code,
   input  logic [CODE_BITS-1:0]      wr_prefix,
   input  logic [lzwc_pkg::BYTE_W-1:0] wr_byte,
   output logic [CODE_BITS-1:0]      slot_code,
   output logic [CODE_BITS-1:0]      entry_prefix,
   output logic [lzwc_pkg::BYTE_W-1:0] entry_byte,
   output logic [CODE_BITS:0]        entry_slot
);

   localparam int IDX_BITS  = CODE_BITS + 1;
   localparam int SLOT_NUM  = 1 << IDX_BITS;
   localparam int CODE_NUM  = 1 << CODE_BITS;
   localparam int ENTRY_W   = IDX_BITS + CODE_BITS + lzwc_pkg::BYTE_W;

   // Two-state storage: unwritten words read as zero, which decodes as empty.
   bit [CODE_BITS-1:0] slot_mem [SLOT_NUM];
   bit [ENTRY_W-1:0]   entry_mem [CODE_NUM];

   bit [CODE_BITS-1:0] slot_rd_ff;
   bit [ENTRY_W-1:0]   entry_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         slot_mem[wr_slot] <= wr_code;
      end
      if (cmd.slot_rd) begin
         slot_rd_ff <= slot_mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         entry_mem[wr_code] <= {wr_slot, wr_prefix, wr_byte};
      end
      if (cmd.entry_rd) begin
         entry_rd_ff <= entry_mem[rd_code];
      end
   end

   assign slot_code    = slot_rd_ff;
   assign entry_byte   = entry_rd_ff[lzwc_pkg::BYTE_W-1:0];
   assign entry_prefix = entry_rd_ff[lzwc_pkg::BYTE_W +: CODE_BITS];
   assign entry_slot   = entry_rd_ff[ENTRY_W-1 -: IDX_BITS];

endmodule

// ===== design/lzwc_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW output queue
// Two-entry queue between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwc_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  lzwc_pkg::out_item_type push_item,
   output logic                   push_space,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // code[15:0]
   output logic                   rsp_tlast    // last
);

   lzwc_pkg::out_item_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_space = (count_ff != 2'd2);
   assign push       = push_valid && push_space;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = entries_ff[rd_ptr_ff].code;
   assign rsp_tlast  = entries_ff[rd_ptr_ff].last;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   `LZWC_NEXT(a_push_hold, push_valid && !push_space, push_valid, "waiting item dropped")
   `LZWC_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 2'd1, "lost a push")
   `LZWC_IMPLY(a_ptr_gap, count_ff == 2'd0, wr_ptr_ff == rd_ptr_ff, "pointers diverged")

endmodule

// ===== design/lzwc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW sequencer
// Holds the prefix and code counter, hashes each pair, walks the probe chain
// through the dictionary and emits codes into the output queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwc_ctrl #(
   parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [lzwc_pkg::BYTE_W-1:0] in_byte,
   input  logic                        in_eod,
   output logic                        emit_valid,
   output lzwc_pkg::out_item_type      emit_item,
   input  logic                        emit_space,
   output lzwc_pkg::dict_cmd_type      cmd,
   output logic [CODE_BITS:0]          rd_slot,
   output logic [CODE_BITS-1:0]        rd_code,
   output logic [CODE_BITS:0]          wr_slot,
   output logic [CODE_BITS-1:0]        wr_code,
   output logic [CODE_BITS-1:0]        wr_prefix,
   output logic [lzwc_pkg::BYTE_W-1:0] wr_byte,
   input  logic [CODE_BITS-1:0]        slot_code,
   input  logic [CODE_BITS-1:0]        entry_prefix,
   input  logic [lzwc_pkg::BYTE_W-1:0] entry_byte,
   input  logic [CODE_BITS:0]          entry_slot
);

   localparam int IDX_BITS = CODE_BITS + 1;
   localparam int KEY_W    = CODE_BITS + lzwc_pkg::BYTE_W;
   localparam logic [CODE_BITS-1:0] CODE_LIMIT = '1;
   localparam logic [CODE_BITS-1:0] FIRST_CODE = CODE_BITS'(lzwc_pkg::FIRST_CODE);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_SLOT_CHK,
      S_ENTRY_CHK,
      S_MISS,
      S_FLUSH
   } state_type;

   state_type                   state_ff, state_in;
   logic [CODE_BITS-1:0]        prefix_ff, prefix_in;
   logic                        have_ff, have_in;
   logic [CODE_BITS-1:0]        next_ff, next_in;
   logic [lzwc_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        eod_ff, eod_in;
   logic [IDX_BITS-1:0]         slot_ff, slot_in;
   logic [CODE_BITS-1:0]        code_ff, code_in;

   logic [KEY_W-1:0] key;
   logic [31:0]      product;
   logic             accept;
   logic             slot_live;
   logic             pair_match;

   // The slot index is the top bits of the low word of key times the constant.
   assign key     = {prefix_ff, in_byte};
   assign product = 32'(key) * lzwc_pkg::HASH_MULT;

   assign in_ready = (state_ff == S_IDLE);
   assign accept   = in_valid && in_ready;

   // A slot holds a live code only inside the current stream's code range.
   assign slot_live  = (slot_code >= FIRST_CODE) && (slot_code < next_ff);
   assign pair_match = (entry_prefix == prefix_ff) && (entry_byte == byte_ff);

   assign wr_slot   = slot_ff;
   assign wr_code   = next_ff;
   assign wr_prefix = prefix_ff;
   assign wr_byte   = byte_ff;
   assign rd_code   = slot_code;

   always_comb begin
      state_in   = state_ff;
      prefix_in  = prefix_ff;
      have_in    = have_ff;
      next_in    = next_ff;
      byte_in    = byte_ff;
      eod_in     = eod_ff;
      slot_in    = slot_ff;
      code_in    = code_ff;
      cmd        = '0;
      rd_slot    = slot_ff;
      emit_valid = 1'b0;
      emit_item  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in = in_byte;
               eod_in  = in_eod;
               slot_in = product[31 -: IDX_BITS];
               if (!have_ff) begin
                  prefix_in = CODE_BITS'(in_byte);
                  have_in   = 1'b1;
                  state_in  = in_eod ? S_FLUSH : S_IDLE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            cmd.slot_rd = 1'b1;
            state_in    = S_SLOT_CHK;
         end
         S_SLOT_CHK: begin
            if (slot_live) begin
               cmd.entry_rd = 1'b1;
               code_in      = slot_code;
               state_in     = S_ENTRY_CHK;
            end else begin
               state_in = S_MISS;
            end
         end
         S_ENTRY_CHK: begin
            // A code whose entry names another slot is a stale leftover: empty.
            if (entry_slot != slot_ff) begin
               state_in = S_MISS;
            end else if (pair_match) begin
               prefix_in = code_ff;
               state_in  = eod_ff ? S_FLUSH : S_IDLE;
            end else begin
               rd_slot     = slot_ff + 1'b1;
               cmd.slot_rd = 1'b1;
               slot_in     = slot_ff + 1'b1;
               state_in    = S_SLOT_CHK;
            end
         end
         S_MISS: begin
            emit_valid     = 1'b1;
            emit_item.code = lzwc_pkg::OUT_CODE_W'(prefix_ff);
            emit_item.last = 1'b0;
            if (emit_space) begin
               if (next_ff < CODE_LIMIT) begin
                  cmd.wr  = 1'b1;
                  next_in = next_ff + 1'b1;
               end
               prefix_in = CODE_BITS'(byte_ff);
               state_in  = eod_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            emit_valid     = 1'b1;
            emit_item.code = lzwc_pkg::OUT_CODE_W'(prefix_ff);
            emit_item.last = 1'b1;
            if (emit_space) begin
               prefix_in = '0;
               have_in   = 1'b0;
               next_in   = FIRST_CODE;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         prefix_ff <= '0;
         have_ff   <= 1'b0;
         next_ff   <= FIRST_CODE;
      end else begin
         state_ff  <= state_in;
         prefix_ff <= prefix_in;
         have_ff   <= have_in;
         next_ff   <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eod_ff  <= eod_in;
      slot_ff <= slot_in;
      code_ff <= code_in;
   end

   `LZWC_NEXT(a_insert_bumps, cmd.wr, next_ff == $past(next_ff) + 1'b1, "insert did not advance code counter")
   `LZWC_IMPLY(a_insert_room, cmd.wr, next_ff < CODE_LIMIT, "insert past the code limit")
   `LZWC_IMPLY(a_entry_range, cmd.entry_rd, slot_code >= FIRST_CODE && slot_code < next_ff, "entry read outside live codes")
   `LZWC_NEXT(a_flush_clears, emit_valid && emit_space && emit_item.last, !have_ff && next_ff == FIRST_CODE, "flush left stream state")

endmodule
